@@ src/sgag_pkg.sv @@
package sgag_pkg;

  typedef enum logic [1:0] {
    OP_GATHER      = 2'd0,
    OP_SCATTER     = 2'd1,
    OP_SCATTER_ADD = 2'd2,
    OP_SCATTER_ALT = 2'd3
  } op_mode_e;

  typedef enum logic [3:0] {
    REG_OP_MODE        = 4'd0,
    REG_NUM_DIMS       = 4'd1,
    REG_SELECTED_DIM   = 4'd2,
    REG_EXTENTS        = 4'd3,
    REG_INDEX_STRIDES  = 4'd4,
    REG_FULL_STRIDES   = 4'd5,
    REG_REDUCED_STRIDES = 4'd6,
    REG_INDEXED_EXTENT = 4'd7,
    REG_UNUSED_8       = 4'd8,
    REG_UNUSED_9       = 4'd9,
    REG_UNUSED_10      = 4'd10,
    REG_UNUSED_11      = 4'd11,
    REG_UNUSED_12      = 4'd12,
    REG_UNUSED_13      = 4'd13,
    REG_UNUSED_14      = 4'd14,
    REG_UNUSED_15      = 4'd15
  } reg_index_e;

  localparam logic KIND_LINEAR = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  typedef struct packed {
    op_mode_e    op_mode;
    logic [2:0]  num_dims;
    logic [1:0]  selected_dim;
    logic [63:0] extents;
    logic [63:0] index_strides;
    logic [63:0] full_strides;
    logic [63:0] reduced_strides;
    logic [15:0] indexed_extent;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] operand;
  } entry_t;

endpackage

@@ src/strided_gather_scatter_address_gen_unit.sv @@
// A linear-number beat leaves the queue and then, for each dimension in use, runs
// a 32-step radix-2 divide and three multiply-accumulate pairs; an index-value
// beat leaves the queue and takes one multiply step and one output step. The back
// end works on one beat at a time, the next one starting the cycle after a result
// is taken; a two-entry queue lets the input side keep accepting. Reset is
// asynchronous, active low, and clears the queue, the pending offsets and the
// configuration.
module strided_gather_scatter_address_gen_unit #(
  parameter int unsigned MAX_DIMS   = 4,
  parameter int unsigned FIELD_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [3:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: linear_index [31:0], index_value [63:32].
  input  logic [63:0]  s_tdata,
  // tuser: kind [0].
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: index_address [31:0], read_address [63:32], write_address [95:64],
  // in_range [96], accumulate [97], zero fill [103:98].
  output logic [103:0] m_tdata,
  // tuser: answers_kind [0].
  output logic [0:0]   m_tuser
);
  import sgag_pkg::*;

  cfg_t   cfg;
  entry_t q_wdata, q_rdata;
  logic   q_full, q_push, q_pop, q_valid;
  logic   in_range, accumulate;
  logic [31:0] index_address, read_address, write_address;

  sgag_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .in_kind_i   (s_tuser[0]),
    .in_linear_i (s_tdata[31:0]),
    .in_value_i  (s_tdata[63:32]),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata),
    .cfg_o       (cfg)
  );

  sgag_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  sgag_back #(
    .MAX_DIMS   (MAX_DIMS),
    .FIELD_BITS (FIELD_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .q_valid_i        (q_valid),
    .q_data_i         (q_rdata),
    .q_pop_o          (q_pop),
    .out_valid_o      (m_tvalid),
    .out_ready_i      (m_tready),
    .out_kind_o       (m_tuser[0]),
    .out_index_addr_o (index_address),
    .out_read_addr_o  (read_address),
    .out_write_addr_o (write_address),
    .out_in_range_o   (in_range),
    .out_accumulate_o (accumulate)
  );

  assign m_tdata = {6'b0, accumulate, in_range, write_address, read_address, index_address};
endmodule

@@ src/sgag_fifo.sv @@
module sgag_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sgag_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sgag_pkg::entry_t rdata_o
);
  import sgag_pkg::*;

  entry_t     mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end
endmodule

@@ src/sgag_front.sv @@
module sgag_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [3:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_kind_i,
  input  logic [31:0]      in_linear_i,
  input  logic [31:0]      in_value_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output sgag_pkg::entry_t q_data_o,
  output sgag_pkg::cfg_t   cfg_o
);
  import sgag_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o      = 1'b1;
  assign in_ready_o       = !q_full_i;
  assign q_push_o         = in_valid_i && !q_full_i;
  assign q_data_o.kind    = in_kind_i;
  assign q_data_o.operand = in_kind_i ? in_value_i : in_linear_i;
  assign cfg_o            = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.op_mode         <= OP_GATHER;
      cfg_q.num_dims        <= 3'd1;
      cfg_q.selected_dim    <= 2'd0;
      cfg_q.extents         <= '0;
      cfg_q.index_strides   <= '0;
      cfg_q.full_strides    <= '0;
      cfg_q.reduced_strides <= '0;
      cfg_q.indexed_extent  <= '0;
    end else if (cfg_valid_i) begin
      unique case (reg_index_e'(cfg_index_i))
        REG_OP_MODE:         cfg_q.op_mode         <= op_mode_e'(cfg_data_i[1:0]);
        REG_NUM_DIMS:        cfg_q.num_dims        <= cfg_data_i[2:0];
        REG_SELECTED_DIM:    cfg_q.selected_dim    <= cfg_data_i[1:0];
        REG_EXTENTS:         cfg_q.extents         <= cfg_data_i;
        REG_INDEX_STRIDES:   cfg_q.index_strides   <= cfg_data_i;
        REG_FULL_STRIDES:    cfg_q.full_strides    <= cfg_data_i;
        REG_REDUCED_STRIDES: cfg_q.reduced_strides <= cfg_data_i;
        REG_INDEXED_EXTENT:  cfg_q.indexed_extent  <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end
endmodule

@@ src/sgag_back.sv @@
module sgag_back #(
  parameter int unsigned MAX_DIMS   = 4,
  parameter int unsigned FIELD_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sgag_pkg::cfg_t   cfg_i,
  input  logic             q_valid_i,
  input  sgag_pkg::entry_t q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_kind_o,
  output logic [31:0]      out_index_addr_o,
  output logic [31:0]      out_read_addr_o,
  output logic [31:0]      out_write_addr_o,
  output logic             out_in_range_o,
  output logic             out_accumulate_o
);
  import sgag_pkg::*;

  localparam int unsigned DimW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_MUL, S_ACC, S_IMUL, S_IACC
  } state_e;

  function automatic logic [FIELD_BITS-1:0] field_of(input logic [63:0] p,
                                                     input logic [3:0] d);
    int unsigned sh;
    logic [63:0] s;
    sh = int'(d) * FIELD_BITS;
    s  = p >> (sh % 64);
    if (sh >= 64) begin
      return '0;
    end
    return s[FIELD_BITS-1:0];
  endfunction

  state_e            state_q;
  logic [DimW-1:0]   d_q;
  logic [4:0]        cnt_q;
  logic [1:0]        sel_q;
  logic [31:0]       rem_q, quot_q, prod_q;
  logic [31:0]       idx_acc_q, full_acc_q, red_acc_q;
  logic [31:0]       pend_full_q, pend_red_q;
  logic              val_q, kind_q, inr_q, acc_q;
  logic [31:0]       idx_o_q, rd_o_q, wr_o_q;

  logic [3:0]            d_ext, nd;
  logic [DimW-1:0]       d_start;
  logic [FIELD_BITS-1:0] ext, stride;
  logic [32:0]           shifted;
  logic                  fits;
  logic [31+FIELD_BITS:0] product;
  logic                  skip;
  logic [31:0]           sel_addr, red_next;
  logic                  neg;

  assign d_ext = 4'(d_q);

  always_comb begin
    nd = {1'b0, cfg_i.num_dims};
    if (nd == 4'd0) begin
      nd = 4'd1;
    end
    if (nd > 4'(MAX_DIMS)) begin
      nd = 4'(MAX_DIMS);
    end
    d_start = DimW'(nd - 4'd1);
  end

  assign ext     = field_of(cfg_i.extents, d_ext);
  assign shifted = {rem_q, quot_q[31]};
  assign fits    = shifted >= {17'b0, 16'(ext)};

  always_comb begin
    unique case (sel_q)
      2'd0:    stride = field_of(cfg_i.index_strides, d_ext);
      2'd1:    stride = field_of(cfg_i.full_strides, d_ext);
      default: stride = field_of(cfg_i.reduced_strides, d_ext);
    endcase
    if (state_q == S_IMUL) begin
      stride = field_of(cfg_i.reduced_strides, {2'b0, cfg_i.selected_dim});
    end
  end

  assign product  = rem_q * stride;
  assign skip     = (d_ext == {2'b0, cfg_i.selected_dim});
  assign red_next = skip ? red_acc_q : red_acc_q + prod_q;
  assign sel_addr = pend_red_q + prod_q;
  assign neg      = rem_q[31];

  assign q_pop_o          = (state_q == S_IDLE) && q_valid_i && !val_q;
  assign out_valid_o      = val_q;
  assign out_kind_o       = kind_q;
  assign out_index_addr_o = idx_o_q;
  assign out_read_addr_o  = rd_o_q;
  assign out_write_addr_o = wr_o_q;
  assign out_in_range_o   = inr_q;
  assign out_accumulate_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      val_q       <= 1'b0;
      pend_full_q <= '0;
      pend_red_q  <= '0;
      d_q         <= '0;
      cnt_q       <= '0;
      sel_q       <= '0;
    end else begin
      if (val_q && out_ready_i) begin
        val_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            if (q_data_i.kind) begin
              rem_q   <= q_data_i.operand;
              state_q <= S_IMUL;
            end else begin
              quot_q     <= q_data_i.operand;
              rem_q      <= '0;
              cnt_q      <= '0;
              d_q        <= d_start;
              idx_acc_q  <= '0;
              full_acc_q <= '0;
              red_acc_q  <= '0;
              state_q    <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_q  <= fits ? 32'(shifted - {17'b0, 16'(ext)}) : shifted[31:0];
          quot_q <= {quot_q[30:0], fits};
          cnt_q  <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            sel_q   <= 2'd0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= product[31:0];
          state_q <= S_ACC;
        end
        S_ACC: begin
          unique case (sel_q)
            2'd0: begin
              idx_acc_q <= idx_acc_q + prod_q;
              sel_q     <= 2'd1;
              state_q   <= S_MUL;
            end
            2'd1: begin
              full_acc_q <= full_acc_q + prod_q;
              sel_q      <= 2'd2;
              state_q    <= S_MUL;
            end
            default: begin
              red_acc_q <= red_next;
              if (d_q == '0) begin
                pend_full_q <= full_acc_q;
                pend_red_q  <= red_next;
                val_q       <= 1'b1;
                kind_q      <= 1'b0;
                idx_o_q     <= idx_acc_q;
                rd_o_q      <= '0;
                wr_o_q      <= '0;
                inr_q       <= 1'b0;
                acc_q       <= 1'b0;
                state_q     <= S_IDLE;
              end else begin
                d_q     <= d_q - DimW'(1);
                rem_q   <= '0;
                cnt_q   <= '0;
                state_q <= S_DIV;
              end
            end
          endcase
        end
        S_IMUL: begin
          prod_q  <= product[31:0];
          state_q <= S_IACC;
        end
        S_IACC: begin
          val_q   <= 1'b1;
          kind_q  <= 1'b1;
          idx_o_q <= '0;
          inr_q   <= !neg && (rem_q < {16'b0, cfg_i.indexed_extent});
          if (cfg_i.op_mode == OP_GATHER) begin
            rd_o_q <= sel_addr;
            wr_o_q <= pend_full_q;
            acc_q  <= 1'b0;
          end else begin
            rd_o_q <= pend_full_q;
            wr_o_q <= sel_addr;
            acc_q  <= (cfg_i.op_mode == OP_SCATTER_ADD);
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/sgag_checker.sv @@
module sgag_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic [0:0]   m_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Result beat dropped or changed under backpressure.");

  a_linear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tuser[0] |-> m_tdata[97:32] == 66'd0)
    else $error("Linear-number result carries index-value fields.");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'd0)
    else $error("Index-value result carries an index-tensor address.");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[103:98] == 6'd0)
    else $error("Fill bits of a result beat are not zero.");
endmodule

bind strided_gather_scatter_address_gen_unit sgag_checker u_sgag_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ tb/strided_gather_scatter_address_gen_unit_test.sv @@
module strided_gather_scatter_address_gen_unit_test;
  import sgag_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [31:0] index_address;
    logic [31:0] read_address;
    logic [31:0] write_address;
    logic        in_range;
    logic        accumulate;
  } addr_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [3:0]    cfg_index_i = '0;
  logic [63:0]   cfg_data_i = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [63:0]   s_tdata = '0;
  logic [0:0]    s_tuser = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [103:0]  m_tdata;
  logic [0:0]    m_tuser;

  strided_gather_scatter_address_gen_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk_i = ~clk_i;

  op_mode_e     mode_q;
  logic [2:0]   dims_q;
  logic [1:0]   sel_q;
  logic [63:0]  extents_q, idx_strides_q, full_strides_q, red_strides_q;
  logic [15:0]  bound_q;
  logic [31:0]  full_offset_q, reduced_offset_q;

  addr_result_t expected_addrs[$];
  int           errors = 0;
  int unsigned  cycle_count = 0;
  bit           calm = 1'b0;

  function automatic logic [31:0] lane(logic [63:0] packed_val, int d);
    return {16'd0, packed_val[d*16 +: 16]};
  endfunction

  function automatic addr_result_t predict_addresses(logic kind, logic [31:0] lin,
                                                     logic [31:0] raw);
    addr_result_t r;
    logic [31:0] full, red, coord, quot, ext, sel_addr;
    int dims;
    r = '0;
    r.kind = kind;
    if (kind == 1'b0) begin
      dims = (dims_q < 1) ? 1 : (dims_q > 4) ? 4 : dims_q;
      full = 0;
      red = 0;
      for (int d = dims - 1; d >= 0; d--) begin
        ext = lane(extents_q, d);
        if (ext == 0) begin
          coord = lin;
          quot = 32'hFFFF_FFFF;
        end else begin
          coord = lin % ext;
          quot = lin / ext;
        end
        r.index_address += coord * lane(idx_strides_q, d);
        full += coord * lane(full_strides_q, d);
        if (d != sel_q) red += coord * lane(red_strides_q, d);
        lin = quot;
      end
      full_offset_q = full;
      reduced_offset_q = red;
    end else begin
      sel_addr = reduced_offset_q + raw * lane(red_strides_q, sel_q);
      r.in_range = !raw[31] && raw < {16'd0, bound_q};
      if (mode_q == OP_GATHER) begin
        r.read_address = sel_addr;
        r.write_address = full_offset_q;
      end else begin
        r.read_address = full_offset_q;
        r.write_address = sel_addr;
        r.accumulate = (mode_q == OP_SCATTER_ADD);
      end
    end
    return r;
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 26);
  endfunction

  task automatic write_reg(reg_index_e idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_OP_MODE:         mode_q = op_mode_e'(val[1:0]);
      REG_NUM_DIMS:        dims_q = val[2:0];
      REG_SELECTED_DIM:    sel_q = val[1:0];
      REG_EXTENTS:         extents_q = val;
      REG_INDEX_STRIDES:   idx_strides_q = val;
      REG_FULL_STRIDES:    full_strides_q = val;
      REG_REDUCED_STRIDES: red_strides_q = val;
      REG_INDEXED_EXTENT:  bound_q = val[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_beat(logic kind, logic [31:0] lin, logic [31:0] raw);
    while (idle_now()) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {raw, lin};
    do @(posedge clk_i); while (!s_tready);
    expected_addrs.push_back(predict_addresses(kind, lin, raw));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_addrs.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic setup(op_mode_e mode, logic [2:0] dims, logic [1:0] sel,
                       logic [63:0] ext, logic [15:0] bound);
    drain();
    write_reg(REG_OP_MODE, mode);
    write_reg(REG_NUM_DIMS, dims);
    write_reg(REG_SELECTED_DIM, sel);
    write_reg(REG_EXTENTS, ext);
    write_reg(REG_INDEX_STRIDES, {$urandom, $urandom});
    write_reg(REG_FULL_STRIDES, {$urandom, $urandom});
    write_reg(REG_REDUCED_STRIDES, {$urandom, $urandom});
    write_reg(REG_INDEXED_EXTENT, bound);
  endtask

  function automatic logic [63:0] rand_extents();
    logic [63:0] e;
    for (int d = 0; d < 4; d++)
      case ($urandom_range(7))
        0: e[d*16 +: 16] = 16'd0;
        1: e[d*16 +: 16] = 16'hFFFF;
        2: e[d*16 +: 16] = 16'd1;
        default: e[d*16 +: 16] = 16'($urandom_range(2, 40));
      endcase
    return e;
  endfunction

  function automatic logic [31:0] rand_index();
    case ($urandom_range(9))
      0: return $urandom;
      1: return -$urandom_range(1, 40);
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom_range(0, 70);
    endcase
  endfunction

  task automatic test_reset_state();
    send_beat(KIND_INDEX, '0, 32'd5);
    send_beat(KIND_LINEAR, 32'hFFFF_FFFF, '0);
    send_beat(KIND_INDEX, $urandom, 32'hFFFF_FFFF);
  endtask

  task automatic test_directed();
    setup(OP_GATHER, 3'd4, 2'd1, {16'd7, 16'd5, 16'd3, 16'd2}, 16'd5);
    send_beat(KIND_LINEAR, 32'd0, '0);
    send_beat(KIND_INDEX, '0, 32'd0);
    send_beat(KIND_INDEX, '0, 32'd4);
    send_beat(KIND_INDEX, '0, 32'd5);
    send_beat(KIND_INDEX, '0, 32'hFFFF_FFFF);
    send_beat(KIND_INDEX, '0, 32'h8000_0000);
    send_beat(KIND_INDEX, '0, 32'h7FFF_FFFF);
    send_beat(KIND_LINEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(KIND_INDEX, 32'hFFFF_FFFF, 32'd2);
    setup(OP_SCATTER, 3'd0, 2'd3, {16'd0, 16'hFFFF, 16'd0, 16'd0}, 16'hFFFF);
    send_beat(KIND_LINEAR, 32'd12345, '0);
    send_beat(KIND_INDEX, '0, 32'd65534);
    send_beat(KIND_INDEX, '0, 32'd65535);
    setup(OP_SCATTER_ADD, 3'd7, 2'd3, {16'hFFFF, 16'd0, 16'd9, 16'd1}, 16'd0);
    send_beat(KIND_LINEAR, 32'h8000_0001, '0);
    send_beat(KIND_INDEX, '0, 32'd0);
    setup(OP_SCATTER_ALT, 3'd2, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 16'd3);
    send_beat(KIND_LINEAR, 32'h5555_AAAA, '0);
    send_beat(KIND_INDEX, '0, 32'd2);
    drain();
    write_reg(REG_UNUSED_8, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_UNUSED_15, '0);
    send_beat(KIND_INDEX, '0, 32'd1);
  endtask

  task automatic test_random_sequences();
    int n;
    n = 0;
    while (n < 1700) begin
      if (n % 150 == 0)
        setup(op_mode_e'($urandom_range(3)), 3'($urandom_range(7)),
              2'($urandom_range(3)), rand_extents(), 16'($urandom_range(0, 64)));
      calm = (n >= 600 && n < 800);
      if ($urandom_range(9) < 8) begin
        send_beat(KIND_LINEAR, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 5000),
                  $urandom);
        repeat ($urandom_range(1, 3)) begin
          send_beat(KIND_INDEX, $urandom, rand_index());
          n++;
        end
      end else
        send_beat(1'($urandom_range(1)), $urandom, $urandom);
      n++;
    end
    calm = 1'b0;
    drain();
  endtask

  always @(posedge clk_i) begin
    addr_result_t got, want;
    if (rst_ni) m_tready <= !idle_now();
    if (m_tvalid && m_tready) begin
      got = '0;
      got.kind = m_tuser[0];
      got.index_address = m_tdata[31:0];
      got.read_address = m_tdata[63:32];
      got.write_address = m_tdata[95:64];
      got.in_range = m_tdata[96];
      got.accumulate = m_tdata[97];
      if (expected_addrs.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        want = expected_addrs.pop_front();
        if (got.kind != want.kind) begin
          $error("answers_kind exp %0d got %0d", want.kind, got.kind); errors++;
        end
        if (got.index_address != want.index_address) begin
          $error("index_address exp %h got %h", want.index_address, got.index_address);
          errors++;
        end
        if (got.read_address != want.read_address) begin
          $error("read_address exp %h got %h", want.read_address, got.read_address);
          errors++;
        end
        if (got.write_address != want.write_address) begin
          $error("write_address exp %h got %h", want.write_address, got.write_address);
          errors++;
        end
        if (got.in_range != want.in_range) begin
          $error("in_range exp %0d got %0d", want.in_range, got.in_range); errors++;
        end
        if (got.accumulate != want.accumulate) begin
          $error("accumulate exp %0d got %0d", want.accumulate, got.accumulate); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == 1_500_000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    mode_q = OP_GATHER;
    dims_q = 3'd1;
    sel_q = '0;
    extents_q = '0;
    idx_strides_q = '0;
    full_strides_q = '0;
    red_strides_q = '0;
    bound_q = '0;
    full_offset_q = '0;
    reduced_offset_q = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed();
    test_random_sequences();
    if (errors == 0 && expected_addrs.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
